/* sv/hcbp_pkg.sv */
package hcbp_pkg;

  localparam logic [1:0] KindLoad   = 2'd0;
  localparam logic [1:0] KindEncode = 2'd1;
  localparam logic [1:0] KindFlush  = 2'd2;

  localparam int unsigned CodeW = 16;
  localparam int unsigned LenW  = 5;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       symbol;
    logic [CodeW-1:0] code_word;
    logic [LenW-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        is_flush_report;
    logic [31:0] total_bits;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [CodeW-1:0] code_word;
    logic [LenW-1:0]  code_length;
  } entry_t;

  // Handoff from the packing stage to the output buffer.
  typedef struct packed {
    logic       push;
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

/* sv/hcbp_code_table.sv */
module hcbp_code_table #(
  parameter int unsigned SYMBOLS = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [$clog2(SYMBOLS)-1:0]    wr_addr_i,
  input  hcbp_pkg::entry_t              wr_data_i,
  input  logic                          rd_en_i,
  input  logic [$clog2(SYMBOLS)-1:0]    rd_addr_i,
  output hcbp_pkg::entry_t              rd_data_o
);
  import hcbp_pkg::*;

  entry_t               mem [SYMBOLS];
  logic [SYMBOLS-1:0]   written_q;
  entry_t               rd_q;
  logic                 rd_written_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_written_q ? rd_q : '0;

endmodule

/* sv/hcbp_packer.sv */
module hcbp_packer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  logic [1:0]         kind_i,
  input  logic               hit_i,
  input  hcbp_pkg::entry_t   entry_i,
  input  logic               room_i,
  output logic               busy_o,
  output hcbp_pkg::push_t    push_o
);
  import hcbp_pkg::*;

  logic        s1_valid_q;
  logic [1:0]  s1_kind_q;
  logic        s1_hit_q;
  logic [7:0]  pend_byte_q, pend_byte_d;
  logic [2:0]  pend_cnt_q, pend_cnt_d;
  logic [31:0] bit_total_q, bit_total_d;

  logic [LenW-1:0]  clen;
  logic [CodeW-1:0] mask;
  logic [LenW-1:0]  shamt;
  logic [LenW-1:0]  sum;
  logic [23:0]      acc;
  logic [1:0]       nres;
  out_item_t        res0, res1;
  logic             has_bits;
  logic             fire;

  always_comb begin
    clen        = (s1_hit_q && s1_kind_q == KindEncode) ? entry_i.code_length : '0;
    mask        = CodeW'((17'd1 << clen) - 17'd1);
    sum         = LenW'({2'b00, pend_cnt_q}) + clen;
    shamt       = LenW'(24) - LenW'({2'b00, pend_cnt_q}) - clen;
    acc         = {pend_byte_q, 16'h0000} | ({8'h00, entry_i.code_word & mask} << shamt);
    has_bits    = pend_cnt_q != 3'd0;
    pend_byte_d = pend_byte_q;
    pend_cnt_d  = pend_cnt_q;
    bit_total_d = bit_total_q;
    nres        = 2'd0;
    res0        = '0;
    res1        = '0;
    unique case (s1_kind_q)
      KindEncode: begin
        bit_total_d = bit_total_q + 32'(clen);
        nres        = sum[4:3];
        pend_cnt_d  = sum[2:0];
        case (sum[4:3])
          2'd0:    pend_byte_d = acc[23:16];
          2'd1:    pend_byte_d = acc[15:8];
          default: pend_byte_d = acc[7:0];
        endcase
        res0 = '{out_byte: acc[23:16], byte_valid: 1'b1, is_flush_report: 1'b0,
                 total_bits: bit_total_d, last: (sum[4:3] == 2'd1)};
        res1 = '{out_byte: acc[15:8], byte_valid: 1'b1, is_flush_report: 1'b0,
                 total_bits: bit_total_d, last: 1'b1};
      end
      KindFlush: begin
        nres        = 2'd1;
        pend_byte_d = '0;
        pend_cnt_d  = '0;
        res0 = '{out_byte: has_bits ? pend_byte_q : 8'h00, byte_valid: has_bits,
                 is_flush_report: 1'b1, total_bits: bit_total_q, last: 1'b1};
      end
      default: ;
    endcase
  end

  // Items without results never wait on the output side.
  assign fire   = s1_valid_q && (nres == 2'd0 || room_i);
  assign busy_o = s1_valid_q && !fire;

  assign push_o = '{push: fire && nres != 2'd0, count: nres, first: res0, second: res1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_kind_q   <= KindLoad;
      s1_hit_q    <= 1'b0;
      pend_byte_q <= '0;
      pend_cnt_q  <= '0;
      bit_total_q <= '0;
    end else begin
      if (fire) begin
        pend_byte_q <= pend_byte_d;
        pend_cnt_q  <= pend_cnt_d;
        bit_total_q <= bit_total_d;
      end
      if (take_i) begin
        s1_valid_q <= 1'b1;
        s1_kind_q  <= kind_i;
        s1_hit_q   <= hit_i;
      end else if (fire) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

endmodule

/* sv/hcbp_out_buf.sv */
module hcbp_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  hcbp_pkg::push_t     push_i,
  output logic                room_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hcbp_pkg::out_item_t out_data_o
);
  import hcbp_pkg::*;

  out_item_t  slot0_q, slot1_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign out_data_o  = slot0_q;
  assign pop         = out_valid_o && out_ready_i;
  // Take a new pair only when the buffer is empty or its last item leaves this cycle.
  assign room_o      = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);

  always_ff @(posedge clk_i) begin
    if (push_i.push) begin
      slot0_q <= push_i.first;
      slot1_q <= push_i.second;
    end else if (pop) begin
      slot0_q <= slot1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (push_i.push) begin
      cnt_q <= push_i.count;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

/* sv/huffman_code_bit_packer_top.sv */
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   in_data_i  (kind, symbol, code_word, code_length)
// out      output     out_valid_o / out_ready_i out_data_o (out_byte, byte_valid, flush, total, last)
//
// One input item per cycle while the packing stage is not held; a result is
// registered in the packing stage, then the output buffer. A two-byte encode
// fills both buffer slots; the table read stage and that buffer set throughput.
// Reset clears the code table valid bits at once; no clearing pass is run.
// Output stalls hold the packing stage, and with it the input, once the
// buffer cannot take the next result; items without results still pass.
module huffman_code_bit_packer_top #(
  parameter int unsigned MAX_CODE_LEN = 16,
  parameter int unsigned SYMBOLS      = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hcbp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hcbp_pkg::out_item_t out_data_o
);
  import hcbp_pkg::*;

  localparam int unsigned AddrW = $clog2(SYMBOLS);
  localparam int unsigned LenCap = (MAX_CODE_LEN < 16) ? MAX_CODE_LEN : 16;
  localparam logic [8:0] SymLimit = 9'(SYMBOLS);

  logic              take;
  logic              hit;
  logic              busy;
  logic              room;
  logic [LenW-1:0]   sat_len;
  entry_t            wr_entry;
  entry_t            rd_entry;
  push_t             push;

  assign in_ready_o = !busy;
  assign take       = in_valid_i && in_ready_o;
  assign hit        = {1'b0, in_data_i.symbol} < SymLimit;
  assign sat_len    = (in_data_i.code_length > LenW'(LenCap)) ? LenW'(LenCap)
                                                              : in_data_i.code_length;
  assign wr_entry   = '{code_word: in_data_i.code_word, code_length: sat_len};

  hcbp_code_table #(
    .SYMBOLS(SYMBOLS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (take && hit && in_data_i.kind == KindLoad),
    .wr_addr_i(in_data_i.symbol[AddrW-1:0]),
    .wr_data_i(wr_entry),
    .rd_en_i  (take && in_data_i.kind == KindEncode),
    .rd_addr_i(in_data_i.symbol[AddrW-1:0]),
    .rd_data_o(rd_entry)
  );

  hcbp_packer u_packer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .kind_i (in_data_i.kind),
    .hit_i  (hit),
    .entry_i(rd_entry),
    .room_i (room),
    .busy_o (busy),
    .push_o (push)
  );

  hcbp_out_buf u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule
